>>> hdl/rpra_pkg.sv
// Package for the relative patch record applier.
// Holds the address width, the word types of both channels and the parser phase codes.
// No dependencies.
package rpra_pkg;

    // Width of the running record address; the write command carries 20 bits.
    localparam int ADDR_BITS     = 20;
    localparam int OUT_ADDR_BITS = 20;
    localparam int DELTA_BITS    = 15;
    localparam int WIDE_BITS     = 32;

    typedef logic [ADDR_BITS-1:0] addr_t;

    // One byte of the patch stream.
    typedef struct packed {
        logic [7:0] patch_byte;
        logic       stream_start;
    } patch_word_t;

    // One memory write command.
    typedef struct packed {
        logic [OUT_ADDR_BITS-1:0] write_address;
        logic [7:0]               write_data;
        logic                     record_done;
    } write_word_t;

    // Parser phase, one-hot.
    typedef enum logic [2:0] {
        PH_HDR_LO = 3'b001,
        PH_HDR_HI = 3'b010,
        PH_DATA   = 3'b100
    } phase_t;

    // Request from the input stage to the parser.
    typedef struct packed {
        logic        go;
        patch_word_t word;
    } parse_req_t;

    // Parser state as seen from outside.
    typedef struct packed {
        phase_t     phase;
        logic       long_record;
        logic [1:0] data_index;
    } parse_status_t;

endpackage

>>> hdl/relative_patch_record_applier.sv
// Top level of the relative patch record applier.
// Input register, record parser and write command register.
// Depends on rpra_pkg and rpra_parser.

// The block takes one patch stream byte per cycle unless stalled and turns every data byte
// of a record into one memory write command; header bytes give no command. A byte enters
// an input register, is decoded by the parser against its state, and its command lands in
// the output register. The sustained rate is one byte per clock while the output is not
// stalled, set by the parser update (one 20-bit add of the delta or of the data index).
// A stalled output register holds the input register only while it carries a data byte;
// header bytes pass on.
module relative_patch_record_applier (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  patch_valid,
    output logic                  patch_stall,
    input  rpra_pkg::patch_word_t patch,
    output logic                  write_valid,
    input  logic                  write_stall,
    output rpra_pkg::write_word_t write_cmd
);
    import rpra_pkg::*;

    logic          s1_valid_reg, s1_valid_next;
    patch_word_t   s1_word_reg;
    logic          out_valid_reg, out_valid_next;
    write_word_t   out_word_reg;

    parse_req_t    req;
    logic          has_result;
    write_word_t   result;
    parse_status_t status;

    logic out_free;
    logic s1_go;
    logic s1_load;
    logic out_load;

    // Flow control between the two stages.
    assign out_free    = !out_valid_reg || !write_stall;
    assign s1_go       = s1_valid_reg && (!has_result || out_free);
    assign patch_stall = s1_valid_reg && !s1_go;
    assign s1_load     = patch_valid && !patch_stall;
    assign out_load    = s1_go && has_result;

    assign req.go   = s1_go;
    assign req.word = s1_word_reg;

    rpra_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .has_result (has_result),
        .result     (result),
        .status     (status)
    );

    // Valid flags of both stages.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_load)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !write_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s1_load)
            s1_word_reg <= patch;
        if (out_load)
            out_word_reg <= result;
    end

    assign write_valid = out_valid_reg;
    assign write_cmd   = out_word_reg;

    // The input stage stalls only while it holds a byte.
    a_stall_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
        patch_stall |-> s1_valid_reg)
        else $error("input stall without a held byte");

    // A decoded data byte always reaches the output register.
    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> write_valid)
        else $error("decoded command lost");

    // A short record never reaches data index two.
    a_short_index: assert property (@(posedge clk) disable iff (!rst_n)
        (status.phase == PH_DATA && !status.long_record) |-> !status.data_index[1])
        else $error("short record index out of range");

    // Outside the data phase the index rests at zero.
    a_idle_index: assert property (@(posedge clk) disable iff (!rst_n)
        (status.phase != PH_DATA) |-> (status.data_index == 2'd0))
        else $error("data index not cleared");

endmodule

>>> hdl/rpra_parser.sv
// Record parser of the relative patch record applier.
// Keeps the header, record address and data index state and decodes one byte.
// Depends on rpra_pkg.
module rpra_parser (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rpra_pkg::parse_req_t   req,
    output logic                   has_result,
    output rpra_pkg::write_word_t  result,
    output rpra_pkg::parse_status_t status
);
    import rpra_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] header_low_reg, header_low_next;
    logic       long_reg, long_next;
    addr_t      addr_reg, addr_next;
    logic [1:0] idx_reg, idx_next;

    // State as this byte sees it, after an optional restart.
    phase_t     eff_phase;
    logic       eff_long;
    addr_t      eff_addr;
    logic [1:0] eff_idx;
    logic [7:0] in_byte;
    logic [DELTA_BITS-1:0] delta;
    addr_t      byte_addr;
    logic [WIDE_BITS-1:0] byte_addr_wide;
    logic       done;

    assign in_byte   = req.word.patch_byte;
    assign eff_phase = req.word.stream_start ? PH_HDR_LO : phase_reg;
    assign eff_long  = req.word.stream_start ? 1'b0 : long_reg;
    assign eff_addr  = req.word.stream_start ? '1 : addr_reg;
    assign eff_idx   = req.word.stream_start ? 2'd0 : idx_reg;

    assign delta          = {in_byte[6:0], header_low_reg};
    assign byte_addr      = eff_addr + ADDR_BITS'(eff_idx);
    assign byte_addr_wide = WIDE_BITS'(byte_addr);
    assign done           = (eff_idx == (eff_long ? 2'd3 : 2'd1));

    // Byte decode and next state.
    always_comb
    begin
        phase_next      = eff_phase;
        header_low_next = header_low_reg;
        long_next       = eff_long;
        addr_next       = eff_addr;
        idx_next        = eff_idx;
        has_result      = 1'b0;
        case (eff_phase)
            PH_HDR_HI:
            begin
                long_next  = in_byte[7];
                addr_next  = eff_addr + ADDR_BITS'(delta);
                idx_next   = 2'd0;
                phase_next = PH_DATA;
            end
            PH_DATA:
            begin
                has_result = 1'b1;
                if (done)
                begin
                    phase_next = PH_HDR_LO;
                    idx_next   = 2'd0;
                end
                else
                begin
                    idx_next = eff_idx + 2'd1;
                end
            end
            default:
            begin
                // Header low byte; stray phase codes behave the same way.
                header_low_next = in_byte;
                phase_next      = PH_HDR_HI;
            end
        endcase
    end

    assign result.write_address = byte_addr_wide[OUT_ADDR_BITS-1:0];
    assign result.write_data    = in_byte;
    assign result.record_done   = done;

    assign status.phase       = phase_reg;
    assign status.long_record = long_reg;
    assign status.data_index  = idx_reg;

    // Parser state registers advance only when a byte is consumed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HDR_LO;
            header_low_reg <= 8'd0;
            long_reg       <= 1'b0;
            addr_reg       <= '1;
            idx_reg        <= 2'd0;
        end
        else if (req.go)
        begin
            phase_reg      <= phase_next;
            header_low_reg <= header_low_next;
            long_reg       <= long_next;
            addr_reg       <= addr_next;
            idx_reg        <= idx_next;
        end
    end

endmodule
